@@ design/pid_pkg.sv @@
package pid_pkg;

    // Fixed field widths of the controller.
    localparam int GAIN_W   = 16;
    localparam int PERIOD_W = 20;
    localparam int DRIVE_W  = 32;
    localparam int FRAC_W   = 8;

    // The shared multiplier takes a 21-bit signed operand (a gain, or the
    // period with a zero sign bit) and one 32-bit digit of the other operand.
    localparam int OPA_W = 21;
    localparam int DIG_W = 32;

    // Reset values of the period register and of the previous error (1.0).
    localparam int PERIOD_INIT   = 1000;
    localparam int LAST_ERR_INIT = 256;

    // Configuration register indexes.
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_KP     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KI     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_KD     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SP     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PERIOD = 3'd4;

    // Product that the shared unit is working on.
    typedef enum logic [1:0] {
        OP_INC,
        OP_P,
        OP_I,
        OP_D
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_INTEG,
        S_COMMIT,
        S_ROUND
    } t_state;

    // Strobes for the multiply-accumulate unit.
    typedef struct packed {
        logic load;
        logic step;
        logic clear;
        logic commit;
    } t_mac_ctrl;

    // Everything the sequencer tells the datapath.
    typedef struct packed {
        t_mac_ctrl mac;
        t_op       op;
        logic      in_ready;
        logic      integ;
        logic      finish;
    } t_ctrl;

    // Order in which the three output products are formed.
    function automatic t_op next_op(input t_op op);
        t_op nxt;
        case (op)
            OP_INC:  nxt = OP_P;
            OP_P:    nxt = OP_I;
            OP_I:    nxt = OP_D;
            default: nxt = OP_D;
        endcase
        return nxt;
    endfunction

endpackage

@@ design/pid_mac.sv @@
module pid_mac
    import pid_pkg::*;
#(
    parameter int ND = 2
) (
    input  logic                            i_clk,
    input  t_mac_ctrl                       i_ctrl,
    input  logic signed [OPA_W-1:0]         i_opa,
    input  logic signed [ND*DIG_W-1:0]      i_opb,
    output logic signed [OPA_W+ND*DIG_W:0]  o_prod,
    output logic signed [OPA_W+ND*DIG_W+2:0] o_sum
);

    localparam int BWP  = ND * DIG_W;
    localparam int PPW  = OPA_W + DIG_W + 1;
    localparam int PW   = OPA_W + BWP + 1;
    localparam int SUMW = PW + 2;

    logic signed [OPA_W-1:0] r_opa;
    logic        [BWP-1:0]   r_opb;
    logic                    r_first;
    logic signed [PW-1:0]    r_prod;
    logic signed [SUMW-1:0]  r_sum;

    logic        [DIG_W-1:0] w_digit;
    logic signed [DIG_W:0]   w_digit_ext;
    logic signed [PPW-1:0]   w_pp;
    logic signed [PW-1:0]    w_pp_ext;

    // The top digit carries the sign; lower digits are unsigned.
    assign w_digit     = r_opb[BWP-1 -: DIG_W];
    assign w_digit_ext = r_first ? $signed({w_digit[DIG_W-1], w_digit})
                                 : $signed({1'b0, w_digit});
    assign w_pp        = r_opa * w_digit_ext;
    assign w_pp_ext    = PW'(w_pp);

    // Operand registers: the second operand shifts out one digit per step,
    // most significant digit first.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_opa   <= i_opa;
            r_opb   <= i_opb;
            r_first <= 1'b1;
        end else if (i_ctrl.step) begin
            r_opb   <= r_opb << DIG_W;
            r_first <= 1'b0;
        end
    end

    // Horner accumulation of the current product.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_prod <= (r_first ? PW'(0) : (r_prod <<< DIG_W)) + w_pp_ext;
        end
    end

    // Running sum of the output products.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_sum <= '0;
        end else if (i_ctrl.commit) begin
            r_sum <= r_sum + SUMW'(r_prod);
        end
    end

    assign o_prod = r_prod;
    assign o_sum  = r_sum;

endmodule

@@ design/pid_seq.sv @@
module pid_seq
    import pid_pkg::*;
#(
    parameter int ND = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_free,
    output t_ctrl o_ctrl
);

    localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_INC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

    // Next state: increment product, integral update, then the three gains.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LOAD;
                    n_op    = OP_INC;
                end
            end
            S_LOAD: begin
                n_state = S_MUL;
                n_cnt   = CNT_W'(ND - 1);
            end
            S_MUL: begin
                if (r_cnt == '0) begin
                    n_state = (r_op == OP_INC) ? S_INTEG : S_COMMIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_INTEG: begin
                n_state = S_LOAD;
                n_op    = next_op(r_op);
            end
            S_COMMIT: begin
                if (r_op == OP_D) begin
                    n_state = S_ROUND;
                end else begin
                    n_state = S_LOAD;
                    n_op    = next_op(r_op);
                end
            end
            S_ROUND: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control strobes decoded from the state.
    always_comb begin
        o_ctrl            = '0;
        o_ctrl.op         = r_op;
        case (r_state)
            S_IDLE:   o_ctrl.in_ready   = 1'b1;
            S_LOAD:   o_ctrl.mac.load   = 1'b1;
            S_MUL:    o_ctrl.mac.step   = 1'b1;
            S_INTEG: begin
                o_ctrl.integ     = 1'b1;
                o_ctrl.mac.clear = 1'b1;
            end
            S_COMMIT: o_ctrl.mac.commit = 1'b1;
            S_ROUND:  o_ctrl.finish     = i_out_free;
            default:  o_ctrl.in_ready   = 1'b0;
        endcase
    end

endmodule

@@ design/pid_controller_step.sv @@
// Discrete PID controller. Each sample on the slave stream gives one result
// on the master stream: error = setpoint - measured; the integral adds
// error * sample_period and saturates at ACCUM_WIDTH bits; the derivative is
// error minus the previous error; drive = (Kp*e + Ki*integral + Kd*d) >> 8,
// rounded toward minus infinity and clipped to 32 bits. All values are
// signed Q8.8. The four products share one 21 x 33 bit multiplier that takes
// 32 bits of its wide operand per cycle, split into ND = ceil(max(ACCUM_WIDTH,
// SAMPLE_WIDTH+2)/32) digits. The next sample is taken once the result is in
// the output register. One sample is worked on at a time; a sample can be
// taken while the previous result still waits in the output register. The
// user must write registers through the cfg port only while no sample is in
// work; the block itself does not enforce it.
module pid_controller_step
    import pid_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACCUM_WIDTH  = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [CFG_AW-1:0]             i_cfg_addr,
    input  logic [((SAMPLE_WIDTH > PERIOD_W) ? SAMPLE_WIDTH : PERIOD_W)-1:0] i_cfg_wdata,
    // Sample stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // measured
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [DRIVE_W-1:0]            m_axis_tdata,  // drive
    output logic [0:0]                    m_axis_tuser   // saturated
);

    localparam int ERR_W = SAMPLE_WIDTH + 1;
    localparam int LEW   = (ERR_W > 10) ? ERR_W : 10;
    localparam int DW    = LEW + 1;
    localparam int BW    = (ACCUM_WIDTH > DW) ? ACCUM_WIDTH : DW;
    localparam int ND    = (BW + DIG_W - 1) / DIG_W;
    localparam int BWP   = ND * DIG_W;
    localparam int PW    = OPA_W + BWP + 1;
    localparam int SUMW  = PW + 2;
    localparam int IW    = PW + 1;

    localparam logic signed [IW-1:0] ACC_MAX =
        {{(IW-ACCUM_WIDTH+1){1'b0}}, {(ACCUM_WIDTH-1){1'b1}}};
    localparam logic signed [IW-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic signed [SUMW-1:0] DRV_MAX =
        {{(SUMW-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [SUMW-1:0] DRV_MIN = ~DRV_MAX;

    t_ctrl w_ctrl;

    // Configuration registers.
    logic signed [GAIN_W-1:0]       r_kp, r_ki, r_kd;
    logic signed [SAMPLE_WIDTH-1:0] r_setpoint;
    logic        [PERIOD_W-1:0]     r_period;

    // Per-sample and kept state.
    logic signed [ERR_W-1:0]        r_err;
    logic signed [DW-1:0]           r_deriv;
    logic signed [LEW-1:0]          r_last_err;
    logic signed [ACCUM_WIDTH-1:0]  r_err_sum;
    logic                           r_int_sat;

    // Output register.
    logic                           r_out_valid;
    logic signed [DRIVE_W-1:0]      r_drive;
    logic                           r_sat;

    logic                           w_in_xfer;
    logic                           w_out_free;
    logic signed [ERR_W-1:0]        w_err;
    logic signed [OPA_W-1:0]        w_opa;
    logic signed [BWP-1:0]          w_opb;
    logic signed [PW-1:0]           w_prod;
    logic signed [SUMW-1:0]         w_sum;
    logic signed [IW-1:0]           w_int_new;
    logic signed [SUMW-1:0]         w_shifted;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_ctrl.in_ready;

    pid_seq #(
        .ND(ND)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_xfer),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        case (w_ctrl.op)
            OP_INC: begin
                w_opa = $signed({1'b0, r_period});
                w_opb = BWP'(r_err);
            end
            OP_P: begin
                w_opa = OPA_W'(r_kp);
                w_opb = BWP'(r_err);
            end
            OP_I: begin
                w_opa = OPA_W'(r_ki);
                w_opb = BWP'(r_err_sum);
            end
            default: begin
                w_opa = OPA_W'(r_kd);
                w_opb = BWP'(r_deriv);
            end
        endcase
    end

    pid_mac #(
        .ND(ND)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl.mac),
        .i_opa  (w_opa),
        .i_opb  (w_opb),
        .o_prod (w_prod),
        .o_sum  (w_sum)
    );

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_setpoint <= '0;
            r_period   <= PERIOD_W'(PERIOD_INIT);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_KP:     r_kp       <= i_cfg_wdata[GAIN_W-1:0];
                REG_KI:     r_ki       <= i_cfg_wdata[GAIN_W-1:0];
                REG_KD:     r_kd       <= i_cfg_wdata[GAIN_W-1:0];
                REG_SP:     r_setpoint <= i_cfg_wdata[SAMPLE_WIDTH-1:0];
                REG_PERIOD: r_period   <= i_cfg_wdata[PERIOD_W-1:0];
                default:    r_period   <= r_period;
            endcase
        end
    end

    // Error and derivative are formed when the sample transfer completes.
    assign w_err = ERR_W'(r_setpoint) - ERR_W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= LEW'(LAST_ERR_INIT);
        end else if (w_in_xfer) begin
            r_last_err <= LEW'(w_err);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_err   <= w_err;
            r_deriv <= DW'(w_err) - DW'(r_last_err);
        end
    end

    // Saturating integral update from the increment product.
    assign w_int_new = IW'(r_err_sum) + IW'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_sum <= '0;
            r_int_sat <= 1'b0;
        end else if (w_ctrl.integ) begin
            if (w_int_new > ACC_MAX) begin
                r_err_sum <= ACCUM_WIDTH'(ACC_MAX);
                r_int_sat <= 1'b1;
            end else if (w_int_new < ACC_MIN) begin
                r_err_sum <= ACCUM_WIDTH'(ACC_MIN);
                r_int_sat <= 1'b1;
            end else begin
                r_err_sum <= ACCUM_WIDTH'(w_int_new);
                r_int_sat <= 1'b0;
            end
        end
    end

    // Back to Q8.8 by a floor shift, then clip to 32 bits.
    assign w_shifted = w_sum >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.finish) begin
            if (w_shifted > DRV_MAX) begin
                r_drive <= DRIVE_W'(DRV_MAX);
                r_sat   <= 1'b1;
            end else if (w_shifted < DRV_MIN) begin
                r_drive <= DRIVE_W'(DRV_MIN);
                r_sat   <= 1'b1;
            end else begin
                r_drive <= DRIVE_W'(w_shifted);
                r_sat   <= r_int_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_drive;
    assign m_axis_tuser[0] = r_sat;

endmodule

@@ design/pid_chk.sv @@
module pid_chk
    import pid_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [DRIVE_W-1:0]            m_axis_tdata,
    input logic [0:0]                    m_axis_tuser
);

    logic       w_in_xfer;
    logic       w_out_xfer;
    logic [1:0] r_pend;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;

    // Samples taken whose result has not yet been transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_xfer} - {1'b0, w_out_xfer};
        end
    end

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // One sample in work at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !s_axis_tready)
        else $error("sample taken while busy");

    // At most one finished result may wait beside the sample in work.
    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |-> r_pend <= 2'd1)
        else $error("sample taken with two results outstanding");

    // Every result comes from a sample.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> r_pend != 2'd0)
        else $error("result without a sample");

endmodule

bind pid_controller_step pid_chk u_pid_chk (.*);

@@ bench/pid_step_checker.sv @@
module pid_step_checker
    import pid_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACCUM_WIDTH  = 48,
    parameter int CFG_DW       = 20,
    parameter int IN_W         = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port, as seen by the block.
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [CFG_DW-1:0]  i_cfg_wdata,
    // Sample stream.
    input  logic               i_in_tvalid,
    input  logic               i_in_tready,
    input  logic [IN_W-1:0]    i_in_tdata,    // measured
    // Result stream.
    input  logic               i_out_tvalid,
    input  logic               i_out_tready,
    input  logic [DRIVE_W-1:0] i_out_tdata,   // drive
    input  logic [0:0]         i_out_tuser,   // saturated
    output int                 o_fail_count,
    output int                 o_outstanding
);

    localparam longint ACC_MAX     = (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1;
    localparam longint ACC_MIN     = -ACC_MAX - 1;
    localparam longint DRIVE_MAX   = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN   = -DRIVE_MAX - 1;
    // Any product beyond this magnitude saturates the drive anyway.
    localparam longint PRODUCT_CAP = longint'(1) <<< 60;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               saturated;
    } t_control_out;

    // Shadow copy of the registers and of the controller state.
    longint kp, ki, kd, setpoint, period;
    longint integral, prev_error;
    t_control_out drive_q[$];
    int mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic longint capped_product(input longint gain, input longint value);
        longint p;
        p = gain * value;
        if (p > PRODUCT_CAP) begin
            p = PRODUCT_CAP;
        end else if (p < -PRODUCT_CAP) begin
            p = -PRODUCT_CAP;
        end
        return p;
    endfunction

    // One control step: updates the integral and the previous error, and
    // returns the drive with its clip flag.
    function automatic t_control_out next_drive(input longint measured);
        longint err, deriv, total, level;
        t_control_out r;
        err = setpoint - measured;
        deriv = err - prev_error;
        total = integral + err * period;
        r.saturated = 1'b0;
        if (total > ACC_MAX) begin
            integral = ACC_MAX;
            r.saturated = 1'b1;
        end else if (total < ACC_MIN) begin
            integral = ACC_MIN;
            r.saturated = 1'b1;
        end else begin
            integral = total;
        end
        prev_error = err;

        // Q.16 sum, floored back to Q8.8, then clipped to the drive width.
        total = capped_product(kp, err) + capped_product(ki, integral)
              + capped_product(kd, deriv);
        level = total >>> FRAC_W;
        if (level > DRIVE_MAX) begin
            level = DRIVE_MAX;
            r.saturated = 1'b1;
        end else if (level < DRIVE_MIN) begin
            level = DRIVE_MIN;
            r.saturated = 1'b1;
        end
        r.drive = level[DRIVE_W-1:0];
        return r;
    endfunction

    // Results are checked before a new sample is predicted in the same cycle,
    // so a result always meets the expectation queued for it.
    always @(posedge i_clk) begin
        t_control_out want;
        if (!i_rst_n) begin
            kp = '0;
            ki = '0;
            kd = '0;
            setpoint = '0;
            period = longint'(PERIOD_INIT);
            integral = '0;
            prev_error = longint'(LAST_ERR_INIT);
            drive_q.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (drive_q.size() == 0) begin
                    $error("drive transfer with no expectation waiting: drive %0d saturated %0b",
                           $signed(i_out_tdata), i_out_tuser[0]);
                    mismatches++;
                end else begin
                    want = drive_q.pop_front();
                    if (i_out_tdata !== want.drive) begin
                        $error("drive: expected %0d, actual %0d",
                               $signed(want.drive), $signed(i_out_tdata));
                        mismatches++;
                    end
                    if (i_out_tuser[0] !== want.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, i_out_tuser[0]);
                        mismatches++;
                    end
                end
            end

            if (i_in_tvalid && i_in_tready) begin
                drive_q.push_back(next_drive(longint'($signed(i_in_tdata[SAMPLE_WIDTH-1:0]))));
            end

            // Register writes; bits above each register's width are dropped.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_KP:     kp = longint'($signed(i_cfg_wdata[GAIN_W-1:0]));
                    REG_KI:     ki = longint'($signed(i_cfg_wdata[GAIN_W-1:0]));
                    REG_KD:     kd = longint'($signed(i_cfg_wdata[GAIN_W-1:0]));
                    REG_SP:     setpoint = longint'($signed(i_cfg_wdata[SAMPLE_WIDTH-1:0]));
                    REG_PERIOD: period = longint'(i_cfg_wdata[PERIOD_W-1:0]);
                    default: ;
                endcase
            end
        end
        o_outstanding <= drive_q.size();
    end

endmodule

@@ bench/pid_controller_step_test.sv @@
module pid_controller_step_test;
    import pid_pkg::*;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int ACCUM_WIDTH   = 48;
    localparam int CFG_DW        = (SAMPLE_WIDTH > PERIOD_W) ? SAMPLE_WIDTH : PERIOD_W;
    localparam int IN_W          = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int IDLE_PCT      = 33;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int WINDUP_ITEMS  = 30;

    localparam logic [GAIN_W-1:0]       GAIN_MIN   = {1'b1, {(GAIN_W-1){1'b0}}};
    localparam logic [GAIN_W-1:0]       GAIN_MAX   = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic [GAIN_W-1:0]       ONE_Q8     = GAIN_W'(1 << FRAC_W);
    localparam logic [IN_W-1:0]         SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [IN_W-1:0]         SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    // Ones in the write-data bits that no 16-bit register keeps.
    localparam logic [CFG_DW-1:0]       HIGH_JUNK  = {CFG_DW{1'b1}} << GAIN_W;
    localparam logic [CFG_AW-1:0]       REG_LAST   = {CFG_AW{1'b1}};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]  i_cfg_addr = '0;
    logic [CFG_DW-1:0]  i_cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;     // measured
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [DRIVE_W-1:0] m_axis_tdata;          // drive
    logic [0:0]         m_axis_tuser;          // saturated

    int fail_count;
    int outstanding;
    int sent_count = 0;
    int result_count = 0;
    bit steady = 1'b0;
    bit hold_request = 1'b0;

    always #1 i_clk = ~i_clk;

    pid_controller_step #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACCUM_WIDTH  (ACCUM_WIDTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pid_step_checker #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACCUM_WIDTH  (ACCUM_WIDTH),
        .CFG_DW       (CFG_DW),
        .IN_W         (IN_W)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .i_out_tuser   (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Drives one register write; the caller lowers the enable after a group.
    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // Offers one sample, with random gaps unless the steady stretch is on.
    task automatic send_sample(input logic [IN_W-1:0] value);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // Stops offering and waits until every sample has produced its result.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (result_count == sent_count);
    endtask

    // Gain or setpoint value, with junk in the bits the register drops.
    function automatic logic [CFG_DW-1:0] random_gain();
        logic [CFG_DW-1:0] w;
        w = CFG_DW'($urandom);
        case ($urandom_range(7))
            0: w[GAIN_W-1:0] = GAIN_MIN;
            1: w[GAIN_W-1:0] = GAIN_MAX;
            2: w[GAIN_W-1:0] = '0;
            3: w[GAIN_W-1:0] = ONE_Q8;
            4, 5: w[GAIN_W-1:0] = GAIN_W'($urandom_range(2 * ONE_Q8) - ONE_Q8);
            default: ;
        endcase
        return w;
    endfunction

    // Loads a random setting into every register, sometimes also hitting an
    // index that has no register behind it.
    task automatic random_settings();
        logic [CFG_DW-1:0] per;
        cfg_write(REG_KP, random_gain());
        cfg_write(REG_KI, random_gain());
        cfg_write(REG_KD, random_gain());
        cfg_write(REG_SP, random_gain());
        case ($urandom_range(9))
            0: per = '0;
            1: per = CFG_DW'(1);
            2: per = CFG_DW'(1000000);
            3: per = '1;
            4: per = CFG_DW'($urandom);
            default: per = CFG_DW'($urandom_range(2000, 1));
        endcase
        cfg_write(REG_PERIOD, per);
        if ($urandom_range(3) == 0) begin
            cfg_write(CFG_AW'($urandom_range(REG_LAST, REG_PERIOD + 1)), CFG_DW'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, one long hold on request, and the result count.
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) result_count++;
            if (hold_request && !hold_taken) begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || i_cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int phase;
        int n;
        logic [IN_W-1:0] sample;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of Kp, setpoint and period stay; the first derivative
        // is taken against the reset previous error of 1.0.
        cfg_write(REG_KI, CFG_DW'(1));
        cfg_write(REG_KD, CFG_DW'(ONE_Q8));
        i_cfg_we <= 1'b0;
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('1);
        drain();

        // Largest error and period: the drive clips low, junk upper bits are
        // dropped, and writes to unused indexes are ignored.
        cfg_write(REG_KP, HIGH_JUNK | GAIN_MAX);
        cfg_write(REG_KI, HIGH_JUNK | GAIN_MIN);
        cfg_write(REG_KD, HIGH_JUNK | GAIN_MIN);
        cfg_write(REG_SP, HIGH_JUNK | SAMPLE_MAX);
        cfg_write(REG_PERIOD, '1);
        for (n = REG_PERIOD + 1; n <= REG_LAST; n++) cfg_write(CFG_AW'(n), '1);
        i_cfg_we <= 1'b0;
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(IN_W'(1));
        drain();

        // Opposite extremes: the drive clips high, shortest period.
        cfg_write(REG_KP, CFG_DW'(GAIN_MIN));
        cfg_write(REG_KI, CFG_DW'(GAIN_MAX));
        cfg_write(REG_KD, CFG_DW'(GAIN_MAX));
        cfg_write(REG_SP, CFG_DW'(SAMPLE_MIN));
        cfg_write(REG_PERIOD, CFG_DW'(1));
        i_cfg_we <= 1'b0;
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        drain();

        // Zero period: the integral holds, so the drive stays put.
        cfg_write(REG_KP, '0);
        cfg_write(REG_KI, CFG_DW'(1));
        cfg_write(REG_KD, '0);
        cfg_write(REG_SP, '0);
        cfg_write(REG_PERIOD, '0);
        i_cfg_we <= 1'b0;
        send_sample(16'h1234);
        send_sample(16'hEDCC);
        send_sample('0);
        drain();

        // Random phases. One runs without gaps, one holds the result side
        // while samples keep coming, one pauses until all results are back.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_settings();
            steady = (phase == 3);
            if (phase == 5) hold_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 7 && n == PHASE_ITEMS / 2) drain();
                case ($urandom_range(9))
                    0: sample = SAMPLE_MIN;
                    1: sample = SAMPLE_MAX;
                    2: sample = '0;
                    3: sample = IN_W'($urandom_range(2 * ONE_Q8) - ONE_Q8);
                    default: sample = IN_W'($urandom);
                endcase
                send_sample(sample);
            end
            drain();
        end
        steady = 1'b0;

        // Largest error at the longest period: the integral grows by about
        // 2^36 per step and the drive clips.
        cfg_write(REG_KP, random_gain());
        cfg_write(REG_KI, random_gain());
        cfg_write(REG_KD, random_gain());
        cfg_write(REG_SP, CFG_DW'(SAMPLE_MAX));
        cfg_write(REG_PERIOD, '1);
        i_cfg_we <= 1'b0;
        for (n = 0; n < WINDUP_ITEMS; n++) begin
            send_sample(IN_W'(SAMPLE_MIN + $urandom_range(255)));
        end
        drain();

        // Reverse the error so the integral swings through zero to the other sign.
        cfg_write(REG_SP, CFG_DW'(SAMPLE_MIN));
        i_cfg_we <= 1'b0;
        for (n = 0; n < 2 * WINDUP_ITEMS; n++) begin
            send_sample(IN_W'(SAMPLE_MAX - $urandom_range(255)));
        end
        drain();

        // A few steps on the large integral with random gains.
        random_settings();
        for (n = 0; n < PHASE_ITEMS / 2; n++) send_sample(IN_W'($urandom));
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
